// ===== design/sfl_pkg.sv =====
// Shared types and constants for the slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package sfl_pkg;

  // Fixed widths of the request and response fields
  localparam int unsigned OP_W     = 1;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 11;

  // Request operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  // Response status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_USED = 2'd3;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture request, launch memory reads
    logic commit;  // update state, write memories, load response
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_space;  // response register can take a new transaction
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/sfl_ctrl.sv =====
// Controller state machine for the slot allocator.
`timescale 1ns / 1ps
`default_nettype none

module sfl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sfl_pkg::dp_status_t dp_status,
  output sfl_pkg::ctrl_cmd_t     cmd
);

  sfl_pkg::fsm_state_t state_r;
  sfl_pkg::fsm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfl_pkg::FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sfl_pkg::FSM_IDLE: begin
        if (in_valid) begin
          state_nxt = sfl_pkg::FSM_EXEC;
        end
      end
      sfl_pkg::FSM_EXEC: begin
        if (dp_status.out_space) begin
          state_nxt = sfl_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = sfl_pkg::FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      sfl_pkg::FSM_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      sfl_pkg::FSM_EXEC: begin
        cmd.commit = dp_status.out_space;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/sfl_datapath.sv =====
// Datapath for the slot allocator: pointers, link and flag memories, response register.
`timescale 1ns / 1ps
`default_nettype none

module sfl_datapath #(
  parameter int unsigned SLOTS = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire sfl_pkg::ctrl_cmd_t             cmd,
  output sfl_pkg::dp_status_t                 dp_status,
  input  wire logic [sfl_pkg::OP_W-1:0]       in_operation,
  input  wire logic [sfl_pkg::SLOT_W-1:0]     in_slot_to_free,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [sfl_pkg::STATUS_W-1:0]   out_status,
  output logic      [sfl_pkg::SLOT_W-1:0]     out_slot_index,
  output logic      [sfl_pkg::COUNT_W-1:0]    out_live_count
);

  // IW addresses a slot, PW also holds SLOTS itself
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned PW = $clog2(SLOTS + 1);
  localparam int unsigned CW = (PW > sfl_pkg::SLOT_W) ? PW : sfl_pkg::SLOT_W;
  localparam int unsigned LW = (PW > sfl_pkg::COUNT_W) ? PW : sfl_pkg::COUNT_W;
  localparam logic [PW-1:0] SLOTS_P = PW'(SLOTS);

  // Pointer state
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] hw_r, hw_nxt;
  logic [PW-1:0] used_r, used_nxt;

  // Captured request and registered memory reads
  logic [sfl_pkg::OP_W-1:0]   op_r;
  logic [sfl_pkg::SLOT_W-1:0] idx_r;
  logic [PW-1:0]              link_q_r;
  logic                       flag_q_r;

  // Response register
  logic                         out_valid_r, out_valid_nxt;
  logic [sfl_pkg::STATUS_W-1:0] out_status_r, status_nxt;
  logic [sfl_pkg::SLOT_W-1:0]   out_slot_r, slot_nxt;
  logic [sfl_pkg::COUNT_W-1:0]  out_live_r;

  // Memories; flag entries at and above the high-water mark are never used
  logic [PW-1:0] link_mem [SLOTS];
  logic          flag_mem [SLOTS];

  logic [CW-1:0] in_idx_c;
  logic [CW-1:0] idx_c;
  logic [CW-1:0] hw_c;
  logic [CW-1:0] slot_c;
  logic [LW-1:0] live_c;
  logic [IW-1:0] flag_waddr;
  logic          flag_we;
  logic          flag_wdata;
  logic          link_we;

  assign in_idx_c = CW'(in_slot_to_free);
  assign idx_c    = CW'(idx_r);
  assign hw_c     = CW'(hw_r);

  always_comb begin
    head_nxt   = head_r;
    hw_nxt     = hw_r;
    used_nxt   = used_r;
    status_nxt = sfl_pkg::STAT_OK;
    slot_c     = '0;
    flag_we    = 1'b0;
    flag_wdata = 1'b0;
    flag_waddr = head_r[IW-1:0];
    link_we    = 1'b0;
    case (op_r)
      sfl_pkg::OP_ALLOC: begin
        if ((used_r >= SLOTS_P) || (head_r >= SLOTS_P)) begin
          status_nxt = sfl_pkg::STAT_FULL;
        end else begin
          if (hw_r == head_r) begin
            // free list empty: bump the mark
            hw_nxt   = hw_r + PW'(1);
            head_nxt = hw_r + PW'(1);
          end else begin
            head_nxt = link_q_r;
          end
          used_nxt   = used_r + PW'(1);
          slot_c     = CW'(head_r);
          flag_we    = 1'b1;
          flag_wdata = 1'b1;
        end
      end
      sfl_pkg::OP_FREE: begin
        flag_waddr = idx_c[IW-1:0];
        if (idx_c >= hw_c) begin
          status_nxt = sfl_pkg::STAT_RANGE;
        end else if (!flag_q_r) begin
          status_nxt = sfl_pkg::STAT_NOT_USED;
        end else begin
          head_nxt   = idx_c[PW-1:0];
          used_nxt   = (used_r != '0) ? (used_r - PW'(1)) : used_r;
          slot_c     = idx_c;
          flag_we    = 1'b1;
          flag_wdata = 1'b0;
          link_we    = 1'b1;
        end
      end
      default: begin
        status_nxt = sfl_pkg::STAT_OK;
      end
    endcase
    slot_nxt = slot_c[sfl_pkg::SLOT_W-1:0];
    live_c   = LW'(used_nxt);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_operation;
      idx_r    <= in_slot_to_free;
      link_q_r <= link_mem[head_r[IW-1:0]];
      flag_q_r <= flag_mem[in_idx_c[IW-1:0]];
    end
    if (cmd.commit && flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    if (cmd.commit && link_we) begin
      link_mem[flag_waddr] <= head_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      hw_r   <= '0;
      used_r <= '0;
    end else if (cmd.commit) begin
      head_r <= head_nxt;
      hw_r   <= hw_nxt;
      used_r <= used_nxt;
    end
  end

  assign dp_status.out_space = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= status_nxt;
      out_slot_r   <= slot_nxt;
      out_live_r   <= live_c[sfl_pkg::COUNT_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;
  assign out_live_count = out_live_r;

endmodule

`default_nettype wire

// ===== design/slot_allocator_free_list.sv =====
// Top level of the slot allocator with linked free list and bump pointer.
`timescale 1ns / 1ps
`default_nettype none

// Slot allocator over a pool of SLOTS slots. Each request (allocate, or free
// a given slot) yields exactly one response with status, slot index and the
// live count after the request. The cycle a request is accepted launches the
// registered reads of the link memory at the free-list head and of the in-use
// flag memory; the EXEC state then commits the update and loads the response
// register once it has space, and only then is a new request accepted.
// A response waiting on out_ready holds up only the commit of the next
// request. No clearing pass runs after reset: the high-water mark bounds the
// in-use flag entries that have ever been written, and only those are used.
module slot_allocator_free_list #(
  parameter int unsigned SLOTS = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [sfl_pkg::OP_W-1:0]       in_operation,
  input  wire logic [sfl_pkg::SLOT_W-1:0]     in_slot_to_free,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [sfl_pkg::STATUS_W-1:0]   out_status,
  output logic      [sfl_pkg::SLOT_W-1:0]     out_slot_index,
  output logic      [sfl_pkg::COUNT_W-1:0]    out_live_count
);

  sfl_pkg::ctrl_cmd_t  cmd;
  sfl_pkg::dp_status_t dp_status;

  sfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  sfl_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .dp_status       (dp_status),
    .in_operation    (in_operation),
    .in_slot_to_free (in_slot_to_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_slot_index  (out_slot_index),
    .out_live_count  (out_live_count)
  );

endmodule

`default_nettype wire

// ===== design/sfl_checker.sv =====
// Port-level checks for the slot allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sfl_checker #(
  parameter int unsigned SLOTS = 1024
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [sfl_pkg::STATUS_W-1:0] out_status,
  input wire logic [sfl_pkg::SLOT_W-1:0]   out_slot_index,
  input wire logic [sfl_pkg::COUNT_W-1:0]  out_live_count
);

  localparam logic [sfl_pkg::COUNT_W-1:0] FULL_COUNT = sfl_pkg::COUNT_W'(SLOTS);

  // one transaction in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high in the cycle after an accept");

  // error responses carry slot index zero
  a_err_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != sfl_pkg::STAT_OK)) |-> (out_slot_index == '0))
    else $error("non-zero slot index on an error response");

  // pool full only when every slot is live
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == sfl_pkg::STAT_FULL)) |-> (out_live_count == FULL_COUNT))
    else $error("pool full reported with slots still free");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_slot_index) &&
       $stable(out_live_count)))
    else $error("stalled response changed or dropped");

endmodule

bind slot_allocator_free_list sfl_checker #(
  .SLOTS (SLOTS)
) u_sfl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_slot_index (out_slot_index),
  .out_live_count (out_live_count)
);

`default_nettype wire
